// ----- rtl/ihex_pkg.sv -----
// Shared types, codes and helpers for the hex record parser.
package ihex_pkg;

   typedef enum logic [3:0] {
      PH_LINE,
      PH_COUNT,
      PH_ADRHI,
      PH_ADRLO,
      PH_TYPE,
      PH_DATA,
      PH_SUM,
      PH_REST,
      PH_ERROR
   } phase_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_RECORD = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ERR_NO_COLON = 2'd0;
   localparam logic [1:0] ERR_NON_HEX  = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM = 2'd2;

   localparam logic [7:0] REC_DATA      = 8'h00;
   localparam logic [7:0] REC_EOF       = 8'h01;
   localparam logic [7:0] REC_EXT_SEG   = 8'h02;
   localparam logic [7:0] REC_START_SEG = 8'h03;
   localparam logic [7:0] REC_EXT_LIN   = 8'h04;
   localparam logic [7:0] REC_START_LIN = 8'h05;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// ----- rtl/intel_hex_record_parser_core.sv -----
// Hex text record parser: one character in, at most one result out per item.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_char_in
//   rsp     | out       | rsp_valid / rsp_stall  | kind, byte, address, chunk, type,
//           |           |                        | loaded value, error code
//   csr     | in        | csr_write_enable       | csr_write_data (word mode)
//
// One character is taken each unstalled cycle; its result, if any, sits in the output
// register the next cycle. The record start address add happens on the type byte.
// req_stall is high only while a result waits in the output register under rsp_stall.
// Reset is synchronous and returns the parser to line start with bases cleared.
module intel_hex_record_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [31:0] rsp_byte_address,
   output logic        rsp_new_chunk,
   output logic [7:0]  rsp_record_kind,
   output logic [31:0] rsp_loaded_value,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import ihex_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        digit_parity_ff, digit_parity_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  bytes_done_ff, bytes_done_in;
   logic [15:0] record_offset_ff, record_offset_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] linear_base_ff, linear_base_in;
   logic [15:0] segment_base_ff, segment_base_in;
   logic [31:0] segment_start_ff, segment_start_in;
   logic [31:0] linear_start_ff, linear_start_in;
   logic [31:0] current_address_ff, current_address_in;
   logic [31:0] record_start_ff, record_start_in;
   logic [31:0] previous_end_ff, previous_end_in;
   logic [31:0] first_bytes_ff, first_bytes_in;
   logic        halted_ff, halted_in;
   logic        word_mode_ff, word_mode_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic [31:0] address_ff, address_in;
   logic        chunk_ff, chunk_in;
   logic [7:0]  rkind_ff, rkind_in;
   logic [31:0] loaded_ff, loaded_in;
   logic [1:0]  error_ff, error_in;

   logic          accept;
   logic          active;
   logic          is_blank;
   logic          is_colon;
   hex_digit_type hex;
   logic [7:0]    byte_val;
   logic [7:0]    sum_new;
   logic [7:0]    done_next;
   logic          field_phase;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign active      = accept && !halted_ff && (phase_ff != PH_ERROR);
   assign is_blank    = (req_char_in == CHAR_SPACE) || (req_char_in == CHAR_TAB);
   assign is_colon    = (req_char_in == CHAR_COLON);
   assign hex         = hex_decode(req_char_in);
   assign byte_val    = {high_nibble_ff, hex.value};
   assign sum_new     = running_sum_ff + byte_val;
   assign done_next   = bytes_done_ff + 8'd1;
   assign field_phase = (phase_ff != PH_LINE) && (phase_ff != PH_REST)
                        && (phase_ff != PH_ERROR);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         case (phase_ff)
            PH_LINE: begin
               if (is_colon) begin
                  phase_in = PH_COUNT;
               end else if (!is_blank) begin
                  phase_in = PH_ERROR;
               end
            end
            PH_REST: begin
               if (req_char_in == CHAR_NEWLINE) begin
                  phase_in = PH_LINE;
               end
            end
            PH_COUNT, PH_ADRHI, PH_ADRLO, PH_TYPE, PH_DATA, PH_SUM: begin
               if (!hex.ok) begin
                  phase_in = PH_ERROR;
               end else if (digit_parity_ff) begin
                  case (phase_ff)
                     PH_COUNT: phase_in = PH_ADRHI;
                     PH_ADRHI: phase_in = PH_ADRLO;
                     PH_ADRLO: phase_in = PH_TYPE;
                     PH_TYPE:  phase_in = (byte_count_ff == 8'd0) ? PH_SUM : PH_DATA;
                     PH_DATA:  phase_in = (done_next == byte_count_ff) ? PH_SUM : PH_DATA;
                     PH_SUM:   phase_in = (sum_new != 8'd0) ? PH_ERROR : PH_REST;
                     default:  phase_in = phase_ff;
                  endcase
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // datapath and result register
   always_comb begin
      high_nibble_in     = high_nibble_ff;
      digit_parity_in    = digit_parity_ff;
      byte_count_in      = byte_count_ff;
      bytes_done_in      = bytes_done_ff;
      record_offset_in   = record_offset_ff;
      record_type_in     = record_type_ff;
      running_sum_in     = running_sum_ff;
      linear_base_in     = linear_base_ff;
      segment_base_in    = segment_base_ff;
      segment_start_in   = segment_start_ff;
      linear_start_in    = linear_start_ff;
      current_address_in = current_address_ff;
      record_start_in    = record_start_ff;
      previous_end_in    = previous_end_ff;
      first_bytes_in     = first_bytes_ff;
      halted_in          = halted_ff;
      word_mode_in       = csr_write_enable ? csr_write_data : word_mode_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      value_in     = value_ff;
      address_in   = address_ff;
      chunk_in     = chunk_ff;
      rkind_in     = rkind_ff;
      loaded_in    = loaded_ff;
      error_in     = error_ff;

      if (active) begin
         if (phase_ff == PH_LINE) begin
            if (is_colon) begin
               digit_parity_in = 1'b0;
               running_sum_in  = 8'd0;
               bytes_done_in   = 8'd0;
            end else if (!is_blank) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ERROR;
               value_in     = 8'd0;
               address_in   = 32'd0;
               chunk_in     = 1'b0;
               rkind_in     = 8'd0;
               loaded_in    = 32'd0;
               error_in     = ERR_NO_COLON;
            end
         end else if (field_phase) begin
            if (!hex.ok) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ERROR;
               value_in     = 8'd0;
               address_in   = 32'd0;
               chunk_in     = 1'b0;
               rkind_in     = 8'd0;
               loaded_in    = 32'd0;
               error_in     = ERR_NON_HEX;
            end else if (!digit_parity_ff) begin
               high_nibble_in  = hex.value;
               digit_parity_in = 1'b1;
            end else begin
               digit_parity_in = 1'b0;
               running_sum_in  = sum_new;
               case (phase_ff)
                  PH_COUNT: byte_count_in = byte_val;
                  PH_ADRHI: record_offset_in = {byte_val, 8'd0};
                  PH_ADRLO: record_offset_in = {record_offset_ff[15:8], byte_val};
                  PH_TYPE: begin
                     record_type_in     = byte_val;
                     record_start_in    = {linear_base_ff, 16'd0}
                                          + {12'd0, segment_base_ff, 4'd0}
                                          + {16'd0, record_offset_ff};
                     current_address_in = record_start_in;
                  end
                  PH_DATA: begin
                     case (bytes_done_ff)
                        8'd0: first_bytes_in[31:24] = byte_val;
                        8'd1: first_bytes_in[23:16] = byte_val;
                        8'd2: first_bytes_in[15:8]  = byte_val;
                        8'd3: first_bytes_in[7:0]   = byte_val;
                        default: first_bytes_in = first_bytes_ff;
                     endcase
                     if (record_type_ff == REC_DATA) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_DATA;
                        value_in     = byte_val;
                        address_in   = current_address_ff;
                        chunk_in     = (bytes_done_ff == 8'd0)
                                       && (record_start_ff != previous_end_ff);
                        rkind_in     = 8'd0;
                        loaded_in    = 32'd0;
                        error_in     = 2'd0;
                        if (!word_mode_ff || bytes_done_ff[0]) begin
                           current_address_in = current_address_ff + 32'd1;
                        end
                     end
                     bytes_done_in = done_next;
                  end
                  PH_SUM: begin
                     rsp_valid_in = 1'b1;
                     value_in     = 8'd0;
                     chunk_in     = 1'b0;
                     loaded_in    = 32'd0;
                     if (sum_new != 8'd0) begin
                        kind_in    = KIND_ERROR;
                        address_in = 32'd0;
                        rkind_in   = 8'd0;
                        error_in   = ERR_CHECKSUM;
                     end else begin
                        kind_in    = KIND_RECORD;
                        address_in = record_start_ff;
                        rkind_in   = record_type_ff;
                        error_in   = 2'd0;
                        case (record_type_ff)
                           REC_DATA: begin
                              chunk_in        = (record_start_ff != previous_end_ff);
                              previous_end_in = current_address_ff;
                           end
                           REC_EOF: halted_in = 1'b1;
                           REC_EXT_SEG: begin
                              segment_base_in = first_bytes_ff[31:16];
                              loaded_in       = {16'd0, first_bytes_ff[31:16]};
                           end
                           REC_START_SEG: begin
                              segment_start_in = first_bytes_ff;
                              loaded_in        = first_bytes_ff;
                           end
                           REC_EXT_LIN: begin
                              linear_base_in = first_bytes_ff[31:16];
                              loaded_in      = {16'd0, first_bytes_ff[31:16]};
                           end
                           REC_START_LIN: begin
                              linear_start_in = first_bytes_ff;
                              loaded_in       = first_bytes_ff;
                           end
                           default: loaded_in = 32'd0;
                        endcase
                     end
                  end
                  default: running_sum_in = sum_new;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_LINE;
         high_nibble_ff     <= 4'd0;
         digit_parity_ff    <= 1'b0;
         byte_count_ff      <= 8'd0;
         bytes_done_ff      <= 8'd0;
         record_offset_ff   <= 16'd0;
         record_type_ff     <= 8'd0;
         running_sum_ff     <= 8'd0;
         linear_base_ff     <= 16'd0;
         segment_base_ff    <= 16'd0;
         segment_start_ff   <= 32'hFFFF_FFFF;
         linear_start_ff    <= 32'hFFFF_FFFF;
         current_address_ff <= 32'd0;
         record_start_ff    <= 32'd0;
         previous_end_ff    <= 32'hFFFF_FFFF;
         first_bytes_ff     <= 32'd0;
         halted_ff          <= 1'b0;
         word_mode_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         high_nibble_ff     <= high_nibble_in;
         digit_parity_ff    <= digit_parity_in;
         byte_count_ff      <= byte_count_in;
         bytes_done_ff      <= bytes_done_in;
         record_offset_ff   <= record_offset_in;
         record_type_ff     <= record_type_in;
         running_sum_ff     <= running_sum_in;
         linear_base_ff     <= linear_base_in;
         segment_base_ff    <= segment_base_in;
         segment_start_ff   <= segment_start_in;
         linear_start_ff    <= linear_start_in;
         current_address_ff <= current_address_in;
         record_start_ff    <= record_start_in;
         previous_end_ff    <= previous_end_in;
         first_bytes_ff     <= first_bytes_in;
         halted_ff          <= halted_in;
         word_mode_ff       <= word_mode_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      address_ff <= address_in;
      chunk_ff   <= chunk_in;
      rkind_ff   <= rkind_in;
      loaded_ff  <= loaded_in;
      error_ff   <= error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_byte_value   = value_ff;
   assign rsp_byte_address = address_ff;
   assign rsp_new_chunk    = chunk_ff;
   assign rsp_record_kind  = rkind_ff;
   assign rsp_loaded_value = loaded_ff;
   assign rsp_error_code   = error_ff;

endmodule

// ----- rtl/ihex_checker.sv -----
// Port-level assertions for the hex record parser, bound to the top level.
module ihex_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_byte_value,
   input logic [31:0] rsp_byte_address,
   input logic [7:0]  rsp_record_kind,
   input logic [31:0] rsp_loaded_value
);
   import ihex_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
                                 && $stable(rsp_byte_address))
      else $error("stalled result item changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind != KIND_UNUSED)
      else $error("illegal result kind");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ERROR |->
         rsp_byte_address == 32'd0 && rsp_record_kind == 8'd0
         && rsp_loaded_value == 32'd0 && rsp_byte_value == 8'd0)
      else $error("error item carries payload");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_result_kind == KIND_ERROR |=> !rsp_valid)
      else $error("item produced after an error");

endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_byte_value   (rsp_byte_value),
   .rsp_byte_address (rsp_byte_address),
   .rsp_record_kind  (rsp_record_kind),
   .rsp_loaded_value (rsp_loaded_value)
);

// ----- dv/ihex_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the hex record parser: tracks the parse and compares every result item.
module ihex_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_result_kind,
   input  logic [7:0]  rsp_byte_value,
   input  logic [31:0] rsp_byte_address,
   input  logic        rsp_new_chunk,
   input  logic [7:0]  rsp_record_kind,
   input  logic [31:0] rsp_loaded_value,
   input  logic [1:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output int          mismatch_count,
   output int          pending
);
   import ihex_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value;
      logic [31:0] address;
      logic        chunk;
      logic [7:0]  rkind;
      logic [31:0] loaded;
      logic [1:0]  code;
   } hex_result_type;

   hex_result_type expected_results [$];

   logic        word_mode;
   phase_type   parse_phase;
   logic [3:0]  upper_digit;
   logic        odd_digit;
   logic [7:0]  count_field;
   logic [7:0]  data_seen;
   logic [15:0] offset_field;
   logic [7:0]  type_field;
   logic [7:0]  byte_sum;
   logic [15:0] lin_base;
   logic [15:0] seg_base;
   logic [31:0] seg_start;
   logic [31:0] lin_start;
   logic [31:0] next_address;
   logic [31:0] run_end;
   logic [31:0] head_bytes;
   logic        stopped;

   initial mismatch_count = 0;

   function automatic int digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic logic [31:0] base_address();
      return {lin_base, 16'h0000} + {12'h000, seg_base, 4'h0} + {16'h0000, offset_field};
   endfunction

   task automatic reset_model();
      word_mode    = 1'b0;
      parse_phase  = PH_LINE;
      upper_digit  = '0;
      odd_digit    = 1'b0;
      count_field  = '0;
      data_seen    = '0;
      offset_field = '0;
      type_field   = '0;
      byte_sum     = '0;
      lin_base     = '0;
      seg_base     = '0;
      seg_start    = '1;
      lin_start    = '1;
      next_address = '0;
      run_end      = '1;
      head_bytes   = '0;
      stopped      = 1'b0;
   endtask

   task automatic queue_result(input logic [1:0] kind, input logic [7:0] value,
                               input logic [31:0] address, input logic chunk,
                               input logic [7:0] type_byte, input logic [31:0] loaded,
                               input logic [1:0] code);
      hex_result_type r;
      r = '{kind, value, address, chunk, type_byte, loaded, code};
      expected_results.push_back(r);
   endtask

   task automatic raise_error(input logic [1:0] code);
      parse_phase = PH_ERROR;
      queue_result(KIND_ERROR, '0, '0, 1'b0, '0, '0, code);
   endtask

   task automatic take_char(input logic [7:0] c);
      int          d;
      logic [7:0]  b;
      logic [31:0] rec_start;
      logic [31:0] loaded;
      logic        chunk;
      if (stopped || parse_phase == PH_ERROR) return;
      if (parse_phase == PH_LINE) begin
         if (c == CHAR_SPACE || c == CHAR_TAB) return;
         if (c != CHAR_COLON) begin
            raise_error(ERR_NO_COLON);
            return;
         end
         parse_phase = PH_COUNT;
         odd_digit   = 1'b0;
         byte_sum    = '0;
         data_seen   = '0;
         return;
      end
      if (parse_phase == PH_REST) begin
         if (c == CHAR_NEWLINE) parse_phase = PH_LINE;
         return;
      end
      d = digit_value(c);
      if (d < 0) begin
         raise_error(ERR_NON_HEX);
         return;
      end
      if (!odd_digit) begin
         upper_digit = 4'(d);
         odd_digit   = 1'b1;
         return;
      end
      odd_digit = 1'b0;
      b = {upper_digit, 4'(d)};
      byte_sum += b;
      case (parse_phase)
         PH_COUNT: begin
            count_field = b;
            parse_phase = PH_ADRHI;
         end
         PH_ADRHI: begin
            offset_field = {b, 8'h00};
            parse_phase  = PH_ADRLO;
         end
         PH_ADRLO: begin
            offset_field[7:0] = b;
            parse_phase       = PH_TYPE;
         end
         PH_TYPE: begin
            type_field   = b;
            next_address = base_address();
            parse_phase  = (count_field == 0) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            if (data_seen < 4) head_bytes[(3 - data_seen) * 8 +: 8] = b;
            if (type_field == REC_DATA) begin
               chunk = (data_seen == 0) && (base_address() != run_end);
               queue_result(KIND_DATA, b, next_address, chunk, REC_DATA, '0, '0);
               if (!word_mode || data_seen[0]) next_address++;
            end
            data_seen++;
            if (data_seen == count_field) parse_phase = PH_SUM;
         end
         PH_SUM: begin
            if (byte_sum != 0) begin
               raise_error(ERR_CHECKSUM);
               return;
            end
            parse_phase = PH_REST;
            rec_start   = base_address();
            chunk       = 1'b0;
            loaded      = '0;
            case (type_field)
               REC_DATA: begin
                  chunk   = (rec_start != run_end);
                  run_end = next_address;
               end
               REC_EOF: stopped = 1'b1;
               REC_EXT_SEG: begin
                  seg_base = head_bytes[31:16];
                  loaded   = {16'h0000, seg_base};
               end
               REC_START_SEG: begin
                  seg_start = head_bytes;
                  loaded    = seg_start;
               end
               REC_EXT_LIN: begin
                  lin_base = head_bytes[31:16];
                  loaded   = {16'h0000, lin_base};
               end
               REC_START_LIN: begin
                  lin_start = head_bytes;
                  loaded    = lin_start;
               end
               default: ;
            endcase
            queue_result(KIND_RECORD, '0, rec_start, chunk, type_field, loaded, '0);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_result();
      hex_result_type want;
      if (expected_results.size() == 0) begin
         $error("result_kind: expected none, actual 0x%0h", rsp_result_kind);
         mismatch_count++;
         return;
      end
      want = expected_results.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
      check_field("byte_value", 32'(want.value), 32'(rsp_byte_value));
      check_field("byte_address", want.address, rsp_byte_address);
      check_field("new_chunk", 32'(want.chunk), 32'(rsp_new_chunk));
      check_field("record_kind", 32'(want.rkind), 32'(rsp_record_kind));
      check_field("loaded_value", want.loaded, rsp_loaded_value);
      check_field("error_code", 32'(want.code), 32'(rsp_error_code));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result();
         if (csr_write_enable) word_mode = csr_write_data;
         if (req_valid && !req_stall) take_char(req_char_in);
      end
      pending <= expected_results.size();
   end

endmodule

// ----- dv/tb_intel_hex_record_parser_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the hex record parser: drives hex text lines and reports the verdict.
module tb_intel_hex_record_parser_core;
   import ihex_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_CHARS   = 45;

   typedef enum int {LINE_CLEAN, LINE_BAD_SUM, LINE_BAD_DIGIT} line_fault_type;
   typedef enum int {END_EOF, END_BAD_SUM, END_BAD_DIGIT, END_NO_COLON} ending_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_byte_value;
   logic [31:0] rsp_byte_address;
   logic        rsp_new_chunk;
   logic [7:0]  rsp_record_kind;
   logic [31:0] rsp_loaded_value;
   logic [1:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data   = 1'b0;

   int          mismatch_count;
   int          pending;
   int          quiet_cycles     = 0;
   int          chars_sent       = 0;
   bit          burst            = 1'b0;
   bit          hold_request     = 1'b0;
   bit          hold_done        = 1'b0;
   logic        word_mode_now    = 1'b0;
   logic [15:0] next_offset      = '0;
   logic [7:0]  payload [0:255];
   logic [7:0]  line_chars [$];

   intel_hex_record_parser_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_address (rsp_byte_address),
      .rsp_new_chunk    (rsp_new_chunk),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_loaded_value (rsp_loaded_value),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ihex_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_address (rsp_byte_address),
      .rsp_new_chunk    (rsp_new_chunk),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_loaded_value (rsp_loaded_value),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit is_hex_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // random letter case for A..F
   function automatic logic [7:0] digit_char(input logic [3:0] n);
      if (n < 10) return 8'h30 + 8'(n);
      return 8'(n - 4'd10) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
   endfunction

   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) return CHAR_NEWLINE;
      do c = 8'($urandom_range(0, 255)); while (is_hex_digit(c));
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_line(input logic [7:0] rtype, input int count,
                            input logic [15:0] offset, input line_fault_type fault);
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] c;
      int         lead;
      int         spot;
      body = {8'(count), offset[15:8], offset[7:0], rtype};
      for (int i = 0; i < count; i++) body.push_back(payload[i]);
      sum = '0;
      foreach (body[i]) sum -= body[i];
      if (fault == LINE_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
      body.push_back(sum);
      line_chars.delete();
      lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (lead) line_chars.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      line_chars.push_back(CHAR_COLON);
      foreach (body[i]) begin
         line_chars.push_back(digit_char(body[i][7:4]));
         line_chars.push_back(digit_char(body[i][3:0]));
      end
      if (fault == LINE_BAD_DIGIT) begin
         spot = $urandom_range(lead + 1, line_chars.size() - 1);
         line_chars[spot] = stray_char();
      end
      // junk after the checksum
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            c = 8'($urandom_range(0, 255));
            line_chars.push_back((c == CHAR_NEWLINE) ? CHAR_SPACE : c);
         end
      end
      line_chars.push_back(CHAR_NEWLINE);
      foreach (line_chars[i]) send_char(line_chars[i]);
   endtask

   task automatic fill_payload(input int count);
      for (int i = 0; i < count; i++) payload[i] = 8'($urandom_range(0, 255));
   endtask

   task automatic send_random_record();
      int          pick;
      int          count;
      logic [7:0]  rtype;
      logic [15:0] offset;
      pick   = $urandom_range(0, 99);
      count  = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
      offset = 16'($urandom);
      if (pick < 70) begin
         rtype = REC_DATA;
         if ($urandom_range(0, 1)) begin
            offset = next_offset;
         end else if ($urandom_range(0, 9) == 0) begin
            offset = 16'hFFFF - 16'($urandom_range(0, 4));
         end
      end else begin
         count = $urandom_range(0, 5);
         if (pick < 76) begin
            rtype = REC_EXT_SEG;
         end else if (pick < 82) begin
            rtype = REC_EXT_LIN;
         end else if (pick < 87) begin
            rtype = REC_START_SEG;
         end else if (pick < 92) begin
            rtype = REC_START_LIN;
         end else begin
            rtype = 8'($urandom_range(int'(REC_START_LIN) + 1, 255));
         end
      end
      fill_payload(count);
      send_line(rtype, count, offset, LINE_CLEAN);
      if (rtype == REC_DATA) next_offset = offset + 16'(word_mode_now ? count / 2 : count);
   endtask

   // wait for every expected item, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_word_mode(input logic value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      word_mode_now = value;
   endtask

   // receiver side
   initial begin
      int free_run;
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            free_run = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 6);
            hold = pick_gap();
            rsp_stall <= 1'b0;
            repeat (free_run) @(posedge clock);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[intel_hex_record_parser_core] ERROR");
         $finish;
      end
   end

   initial begin
      int         phase_start;
      ending_type ending;
      logic [7:0] c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_word_mode(1'b0);

      // directed lines
      send_line(REC_DATA, 0, 16'h0000, LINE_CLEAN);
      payload[0] = 8'hFF; payload[1] = 8'h00;
      send_line(REC_DATA, 2, 16'hFFFF, LINE_CLEAN);
      payload[0] = 8'hFF; payload[1] = 8'hFF;
      send_line(REC_EXT_LIN, 2, 16'h0000, LINE_CLEAN);
      payload[0] = 8'hA5; payload[1] = 8'h5A;
      send_line(REC_DATA, 2, 16'hFFFF, LINE_CLEAN);
      payload[0] = 8'h12; payload[1] = 8'h34;
      send_line(REC_EXT_SEG, 2, 16'h0000, LINE_CLEAN);
      payload[0] = 8'h01; payload[1] = 8'h02; payload[2] = 8'h03; payload[3] = 8'h04;
      send_line(REC_START_SEG, 4, 16'h0000, LINE_CLEAN);
      send_line(REC_START_LIN, 0, 16'h0000, LINE_CLEAN);
      payload[0] = 8'h00;
      send_line(REC_EXT_LIN, 1, 16'h0000, LINE_CLEAN);
      payload[0] = 8'h80;
      send_line(8'hFF, 1, 16'h1234, LINE_CLEAN);
      payload[0] = 8'h00; payload[1] = 8'h00; payload[2] = 8'h00;
      send_line(REC_EXT_SEG, 3, 16'h0000, LINE_CLEAN);
      send_line(REC_EXT_LIN, 2, 16'h0000, LINE_CLEAN);
      fill_payload(3);
      send_line(REC_DATA, 3, 16'h0010, LINE_CLEAN);
      send_line(REC_DATA, 2, 16'h0013, LINE_CLEAN);
      next_offset = 16'h0015;

      for (int p = 0; p < 6; p++) begin
         set_word_mode(p % 2 == 0);
         burst        = (p == 3);
         hold_request = (p == 2);
         phase_start  = chars_sent;
         if (p == 0) begin
            fill_payload(255);
            send_line(REC_DATA, 255, 16'($urandom), LINE_CLEAN);
         end
         while (chars_sent - phase_start < PHASE_CHARS || (hold_request && !hold_done))
            send_random_record();
      end
      burst = 1'b0;

      // one terminal event, then input that must be ignored
      ending = ending_type'($urandom_range(0, 3));
      fill_payload(4);
      case (ending)
         END_EOF:       send_line(REC_EOF, 0, 16'($urandom), LINE_CLEAN);
         END_BAD_SUM:   send_line(REC_DATA, 4, next_offset, LINE_BAD_SUM);
         END_BAD_DIGIT: send_line(REC_DATA, 4, next_offset, LINE_BAD_DIGIT);
         default: begin
            if ($urandom_range(0, 2) == 0) begin
               c = CHAR_NEWLINE;
            end else begin
               do c = 8'($urandom_range(0, 255));
               while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_COLON);
            end
            send_char(c);
         end
      endcase
      send_line(REC_DATA, 4, next_offset, LINE_CLEAN);
      repeat (16) send_char(8'($urandom_range(0, 255)));

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[intel_hex_record_parser_core] OK");
      end else begin
         $display("[intel_hex_record_parser_core] ERROR");
      end
      $finish;
   end

endmodule
